FILE: rtl/eas_pkg.sv
// package for the encoder angle and speed estimator
// holds widths, register reset values, constants and the shared command types
// no dependencies
`timescale 1ns / 1ps

package eas_pkg;

   // field widths
   localparam int COUNT_WIDTH         = 16;
   localparam int APC_WIDTH           = 32;
   localparam int PP_WIDTH            = 5;
   localparam int GAIN_WIDTH          = 16;
   localparam int LIMIT_WIDTH         = 15;
   localparam int MECH_WIDTH          = 28;
   localparam int ELEC_WIDTH          = 32;
   localparam int SPEED_WIDTH         = 16;
   localparam int ESPD_WIDTH          = 21;
   localparam int ANGLE_FRAC_BITS_DEF = 12;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNTS_PER_REV   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_PER_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POLE_PAIR_COUNT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_GAIN       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_LIMIT      = 3'd4;

   // register reset values
   localparam logic [COUNT_WIDTH-1:0] CPR_RESET   = 16'd10000;
   localparam logic [APC_WIDTH-1:0]   APC_RESET   = 32'd2698608;
   localparam logic [PP_WIDTH-1:0]    PP_RESET    = 5'd5;
   localparam logic [GAIN_WIDTH-1:0]  GAIN_RESET  = 16'd1536;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 15'd5000;

   // shared multiplier and arithmetic constants
   localparam int MUL_WIDTH     = 32;
   localparam int PROD_WIDTH    = 2 * MUL_WIDTH;
   localparam int DIFF_WIDTH    = COUNT_WIDTH + 2;
   localparam int RPM_FRAC_BITS = 8;
   localparam int ESPD_SHIFT    = 16;
   // pi/30 in Q.20
   localparam logic [MUL_WIDTH-1:0] ESPD_COEF = 32'd109807;
   localparam logic [MECH_WIDTH-1:0] MECH_MAX = '1;
   localparam logic [ELEC_WIDTH-1:0] ELEC_MAX = '1;
   localparam logic [ESPD_WIDTH-1:0] ESPD_POS_MAX = {1'b0, {(ESPD_WIDTH-1){1'b1}}};
   localparam logic [ESPD_WIDTH-1:0] ESPD_NEG_MIN = {1'b1, {(ESPD_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] counts_per_rev;
      logic [APC_WIDTH-1:0]   angle_per_count;
      logic [PP_WIDTH-1:0]    pole_pair_count;
      logic [GAIN_WIDTH-1:0]  speed_gain;
      logic [LIMIT_WIDTH-1:0] speed_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_MECH,
      MUL_ELEC,
      MUL_RPM,
      MUL_ESPD1,
      MUL_ESPD2
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        load_diff;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        load_mech;
      logic        load_elec;
      logic        update_speed;
      logic        load_out;
   } dp_cmd_type;

endpackage

FILE: rtl/eas_if.sv
// channel interfaces for the estimator: sample, result and register write
// depends on eas_pkg
`timescale 1ns / 1ps

interface eas_req_if;
   import eas_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] position_count;
   logic                   direction;
   logic                   unit_timeout;
   logic [COUNT_WIDTH-1:0] latched_position;

   modport source (output valid, position_count, direction, unit_timeout,
                   latched_position, input ready);
   modport sink (input valid, position_count, direction, unit_timeout,
                 latched_position, output ready);
endinterface

interface eas_rsp_if;
   import eas_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [MECH_WIDTH-1:0]         mech_angle;
   logic [ELEC_WIDTH-1:0]         elec_angle;
   logic signed [SPEED_WIDTH-1:0] speed_rpm;
   logic signed [ESPD_WIDTH-1:0]  elec_speed;

   modport source (output valid, mech_angle, elec_angle, speed_rpm, elec_speed,
                   input ready);
   modport sink (input valid, mech_angle, elec_angle, speed_rpm, elec_speed,
                 output ready);
endinterface

interface eas_csr_if;
   import eas_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/eas_csr.sv
// configuration registers of the estimator
// depends on eas_pkg and eas_if
`timescale 1ns / 1ps

module eas_csr (
   input  logic             clock,
   input  logic             reset,
   eas_csr_if.sink          csr_chan,
   output eas_pkg::cfg_type cfg
);
   import eas_pkg::*;

   cfg_type cfg_ff;

   // always ready, one write per cycle
   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.counts_per_rev  <= CPR_RESET;
         cfg_ff.angle_per_count <= APC_RESET;
         cfg_ff.pole_pair_count <= PP_RESET;
         cfg_ff.speed_gain      <= GAIN_RESET;
         cfg_ff.speed_limit     <= LIMIT_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_COUNTS_PER_REV: begin
               cfg_ff.counts_per_rev <= csr_chan.data[COUNT_WIDTH-1:0];
            end
            CSR_ANGLE_PER_COUNT: begin
               cfg_ff.angle_per_count <= csr_chan.data[APC_WIDTH-1:0];
            end
            CSR_POLE_PAIR_COUNT: begin
               cfg_ff.pole_pair_count <= csr_chan.data[PP_WIDTH-1:0];
            end
            CSR_SPEED_GAIN: begin
               cfg_ff.speed_gain <= csr_chan.data[GAIN_WIDTH-1:0];
            end
            CSR_SPEED_LIMIT: begin
               cfg_ff.speed_limit <= csr_chan.data[LIMIT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: rtl/eas_ctrl.sv
// sequencer of the estimator: steps the shared multiplier through one item
// depends on eas_pkg
`timescale 1ns / 1ps

module eas_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output eas_pkg::dp_cmd_type cmd
);
   import eas_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MECH,
      ST_ELEC,
      ST_RPM,
      ST_HOLD,
      ST_ESPD1,
      ST_ESPD2,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // commands and next state
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_MECH;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_MECH;
            end
         end
         ST_MECH: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_MECH;
            cmd.load_diff = 1'b1;
            state_in      = ST_ELEC;
         end
         ST_ELEC: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_ELEC;
            cmd.load_mech = 1'b1;
            state_in      = ST_RPM;
         end
         ST_RPM: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_RPM;
            cmd.load_elec = 1'b1;
            state_in      = ST_HOLD;
         end
         ST_HOLD: begin
            cmd.update_speed = 1'b1;
            state_in         = ST_ESPD1;
         end
         ST_ESPD1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ESPD1;
            state_in    = ST_ESPD2;
         end
         ST_ESPD2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ESPD2;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to free up
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/eas_dp.sv
// datapath of the estimator: sample registers, count difference, shared
// multiplier, saturation, speed state and output register; depends on eas_pkg
`timescale 1ns / 1ps

module eas_dp #(
   parameter int ANGLE_FRAC_BITS = eas_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  eas_pkg::dp_cmd_type                    cmd,
   input  eas_pkg::cfg_type                       cfg,
   input  logic [eas_pkg::COUNT_WIDTH-1:0]        req_position_count,
   input  logic                                   req_direction,
   input  logic                                   req_unit_timeout,
   input  logic [eas_pkg::COUNT_WIDTH-1:0]        req_latched_position,
   output logic [eas_pkg::MECH_WIDTH-1:0]         rsp_mech_angle,
   output logic [eas_pkg::ELEC_WIDTH-1:0]         rsp_elec_angle,
   output logic signed [eas_pkg::SPEED_WIDTH-1:0] rsp_speed_rpm,
   output logic signed [eas_pkg::ESPD_WIDTH-1:0]  rsp_elec_speed
);
   import eas_pkg::*;

   localparam int MECH_SHIFT = APC_WIDTH - ANGLE_FRAC_BITS;
   localparam int MAG_WIDTH  = DIFF_WIDTH - 1;

   // captured sample
   logic [COUNT_WIDTH-1:0]  pos_ff;
   logic                    dir_ff;
   logic                    tmo_ff;
   logic [COUNT_WIDTH-1:0]  now_ff;
   // speed state
   logic [COUNT_WIDTH-1:0]  prev_ff;
   logic signed [SPEED_WIDTH-1:0] held_ff;
   // working registers
   logic [MAG_WIDTH-1:0]    diff_mag_ff;
   logic                    diff_neg_ff;
   logic [PROD_WIDTH-1:0]   prod_ff;
   logic [MECH_WIDTH-1:0]   mech_ff;
   logic [ELEC_WIDTH-1:0]   elec_ff;
   // output register
   logic [MECH_WIDTH-1:0]   out_mech_ff;
   logic [ELEC_WIDTH-1:0]   out_elec_ff;
   logic signed [SPEED_WIDTH-1:0] out_speed_ff;
   logic signed [ESPD_WIDTH-1:0]  out_espd_ff;

   logic [DIFF_WIDTH-1:0]   diff_raw;
   logic [DIFF_WIDTH-1:0]   diff_neg_val;
   logic [MAG_WIDTH-1:0]    diff_mag;
   logic [PROD_WIDTH-1:0]   mech_wide;
   logic [MECH_WIDTH-1:0]   mech_sat;
   logic [ELEC_WIDTH-1:0]   elec_sat;
   logic [PROD_WIDTH-1:0]   rpm_wide;
   logic [LIMIT_WIDTH-1:0]  rpm_mag;
   logic [SPEED_WIDTH-1:0]  rpm_signed;
   logic [SPEED_WIDTH-1:0]  held_neg;
   logic [LIMIT_WIDTH-1:0]  held_mag;
   logic [PROD_WIDTH-1:0]   espd_wide;
   logic [ESPD_WIDTH-1:0]   espd_sat;
   logic [MUL_WIDTH-1:0]    mul_a;
   logic [MUL_WIDTH-1:0]    mul_b;

   // signed count difference, wrapping at counts per revolution by direction
   always_comb begin
      diff_raw = {2'b00, now_ff} - {2'b00, prev_ff};
      if (dir_ff && (prev_ff > now_ff)) begin
         diff_raw = diff_raw + {2'b00, cfg.counts_per_rev};
      end else if (!dir_ff && (prev_ff < now_ff)) begin
         diff_raw = diff_raw - {2'b00, cfg.counts_per_rev};
      end
      diff_neg_val = ~diff_raw + 1'b1;
      diff_mag     = diff_raw[DIFF_WIDTH-1] ? diff_neg_val[MAG_WIDTH-1:0]
                                            : diff_raw[MAG_WIDTH-1:0];
   end

   // angle saturation
   assign mech_wide = prod_ff >> MECH_SHIFT;
   assign mech_sat  = (|mech_wide[PROD_WIDTH-1:MECH_WIDTH]) ? MECH_MAX
                                                            : mech_wide[MECH_WIDTH-1:0];
   assign elec_sat  = (|prod_ff[PROD_WIDTH-1:ELEC_WIDTH]) ? ELEC_MAX
                                                          : prod_ff[ELEC_WIDTH-1:0];

   // rpm: truncate toward zero, clamp magnitude, restore sign
   always_comb begin
      rpm_wide   = prod_ff >> RPM_FRAC_BITS;
      rpm_mag    = (rpm_wide > {{(PROD_WIDTH-LIMIT_WIDTH){1'b0}}, cfg.speed_limit})
                   ? cfg.speed_limit : rpm_wide[LIMIT_WIDTH-1:0];
      rpm_signed = diff_neg_ff ? (~{1'b0, rpm_mag} + 1'b1) : {1'b0, rpm_mag};
   end

   // held speed magnitude, never the most negative code
   assign held_neg = ~held_ff + 1'b1;
   assign held_mag = held_ff[SPEED_WIDTH-1] ? held_neg[LIMIT_WIDTH-1:0]
                                            : held_ff[LIMIT_WIDTH-1:0];

   // electrical speed: truncate, restore sign, saturate
   always_comb begin
      espd_wide = prod_ff >> ESPD_SHIFT;
      if (held_ff[SPEED_WIDTH-1]) begin
         if (espd_wide > {{(PROD_WIDTH-ESPD_WIDTH){1'b0}}, ESPD_NEG_MIN}) begin
            espd_sat = ESPD_NEG_MIN;
         end else begin
            espd_sat = ~espd_wide[ESPD_WIDTH-1:0] + 1'b1;
         end
      end else begin
         if (espd_wide > {{(PROD_WIDTH-ESPD_WIDTH){1'b0}}, ESPD_POS_MAX}) begin
            espd_sat = ESPD_POS_MAX;
         end else begin
            espd_sat = espd_wide[ESPD_WIDTH-1:0];
         end
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_MECH: begin
            mul_a = {{(MUL_WIDTH-COUNT_WIDTH){1'b0}}, pos_ff};
            mul_b = cfg.angle_per_count;
         end
         MUL_ELEC: begin
            mul_a = {{(MUL_WIDTH-MECH_WIDTH){1'b0}}, mech_sat};
            mul_b = {{(MUL_WIDTH-PP_WIDTH){1'b0}}, cfg.pole_pair_count};
         end
         MUL_RPM: begin
            mul_a = {{(MUL_WIDTH-MAG_WIDTH){1'b0}}, diff_mag_ff};
            mul_b = {{(MUL_WIDTH-GAIN_WIDTH){1'b0}}, cfg.speed_gain};
         end
         MUL_ESPD1: begin
            mul_a = {{(MUL_WIDTH-LIMIT_WIDTH){1'b0}}, held_mag};
            mul_b = {{(MUL_WIDTH-PP_WIDTH){1'b0}}, cfg.pole_pair_count};
         end
         MUL_ESPD2: begin
            mul_a = prod_ff[MUL_WIDTH-1:0];
            mul_b = ESPD_COEF;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // speed state, updated only on a unit timeout
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         held_ff <= '0;
      end else if (cmd.update_speed && tmo_ff) begin
         prev_ff <= now_ff;
         held_ff <= rpm_signed;
      end
   end

   // sample capture, working and output registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pos_ff <= req_position_count;
         dir_ff <= req_direction;
         tmo_ff <= req_unit_timeout;
         now_ff <= req_latched_position;
      end
      if (cmd.load_diff) begin
         diff_mag_ff <= diff_mag;
         diff_neg_ff <= diff_raw[DIFF_WIDTH-1];
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.load_mech) begin
         mech_ff <= mech_sat;
      end
      if (cmd.load_elec) begin
         elec_ff <= elec_sat;
      end
      if (cmd.load_out) begin
         out_mech_ff  <= mech_ff;
         out_elec_ff  <= elec_ff;
         out_speed_ff <= held_ff;
         out_espd_ff  <= espd_sat;
      end
   end

   assign rsp_mech_angle = out_mech_ff;
   assign rsp_elec_angle = out_elec_ff;
   assign rsp_speed_rpm  = out_speed_ff;
   assign rsp_elec_speed = out_espd_ff;

endmodule

FILE: rtl/encoder_angle_speed_estimator_unit.sv
// encoder angle and speed estimator, top level
// the sequencer steps one shared 32x32 multiplier through five products per sample
//   and accepts a new sample only after loading the previous result into the output
//   register, which waits while an earlier result is stalled
// reset: synchronous, active high; registers return to defaults, speed state clears
// depends on eas_pkg, eas_if, eas_csr, eas_ctrl, eas_dp
`timescale 1ns / 1ps

module encoder_angle_speed_estimator_unit #(
   parameter int ANGLE_FRAC_BITS = eas_pkg::ANGLE_FRAC_BITS_DEF
) (
   input logic     clock,
   input logic     reset,
   eas_req_if.sink req_chan,
   eas_rsp_if.source rsp_chan,
   eas_csr_if.sink csr_chan
);
   import eas_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;

   // configuration registers
   eas_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // sequencer
   eas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // datapath
   eas_dp #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .cfg                  (cfg),
      .req_position_count   (req_chan.position_count),
      .req_direction        (req_chan.direction),
      .req_unit_timeout     (req_chan.unit_timeout),
      .req_latched_position (req_chan.latched_position),
      .rsp_mech_angle       (rsp_chan.mech_angle),
      .rsp_elec_angle       (rsp_chan.elec_angle),
      .rsp_speed_rpm        (rsp_chan.speed_rpm),
      .rsp_elec_speed       (rsp_chan.elec_speed)
   );

endmodule

FILE: rtl/eas_checker.sv
// port-level checks for the estimator top level, attached by bind
// depends on eas_pkg and encoder_angle_speed_estimator_unit
`timescale 1ns / 1ps

module eas_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [eas_pkg::MECH_WIDTH-1:0]         mech_angle,
   input logic [eas_pkg::ELEC_WIDTH-1:0]         elec_angle,
   input logic signed [eas_pkg::SPEED_WIDTH-1:0] speed_rpm,
   input logic signed [eas_pkg::ESPD_WIDTH-1:0]  elec_speed
);
   import eas_pkg::*;

   // after reset the block is empty and waiting for an item
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // an accepted item keeps the input closed on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input open right after accepting an item");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(mech_angle)
         && $stable(elec_angle) && $stable(speed_rpm) && $stable(elec_speed)))
      else $error("stalled result changed");

   // clamped speed never reaches the most negative code
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (speed_rpm != {1'b1, {(SPEED_WIDTH-1){1'b0}}}))
      else $error("speed outside clamp range");

endmodule

bind encoder_angle_speed_estimator_unit eas_checker u_eas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .mech_angle (rsp_chan.mech_angle),
   .elec_angle (rsp_chan.elec_angle),
   .speed_rpm  (rsp_chan.speed_rpm),
   .elec_speed (rsp_chan.elec_speed)
);

FILE: tb/encoder_angle_speed_estimator_unit_tb.sv
// testbench for the encoder angle and speed estimator top level
// drives samples and register writes, predicts each result and checks it field by field
// depends on eas_pkg, eas_if and the estimator rtl
`timescale 1ns / 1ps

module encoder_angle_speed_estimator_unit_tb;
   import eas_pkg::*;

   localparam int     ANGLE_FRAC      = ANGLE_FRAC_BITS_DEF;
   // pi/30 in Q.20, rpm to rad/s
   localparam longint RAD_PER_RPM_Q20 = 109807;
   localparam longint ESPD_HIGH       = (longint'(1) << (ESPD_WIDTH - 1)) - 1;
   localparam longint ESPD_LOW        = -(longint'(1) << (ESPD_WIDTH - 1));
   localparam logic [63:0] MECH_CEIL  = (64'd1 << MECH_WIDTH) - 1;
   localparam logic [63:0] ELEC_CEIL  = (64'd1 << ELEC_WIDTH) - 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_FIRST = CSR_SPEED_LIMIT + 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LAST  = '1;
   localparam int     SETTLE_CYCLES   = 16;

   typedef struct {
      logic [COUNT_WIDTH-1:0] position_count;
      logic                   direction;
      logic                   unit_timeout;
      logic [COUNT_WIDTH-1:0] latched_position;
   } sample_type;

   typedef struct {
      logic [MECH_WIDTH-1:0]         mech_angle;
      logic [ELEC_WIDTH-1:0]         elec_angle;
      logic signed [SPEED_WIDTH-1:0] speed_rpm;
      logic signed [ESPD_WIDTH-1:0]  elec_speed;
   } estimate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // clock
   always #5 clock = ~clock;

   eas_req_if req_bus ();
   eas_rsp_if rsp_bus ();
   eas_csr_if csr_bus ();

   encoder_angle_speed_estimator_unit #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // predictor state: register mirror, last latch and held speed
   cfg_type                       model_cfg;
   logic [COUNT_WIDTH-1:0]        model_prev_latch;
   logic signed [SPEED_WIDTH-1:0] model_held_rpm;

   estimate_type pending_estimates[$];

   bit          idle_enabled;
   int          stall_left;
   int unsigned enc_pos;
   logic        enc_dir;
   int          error_count;
   int          samples_sent;
   int          latches_sent;
   int          writes_done;
   int          settings_loaded;
   int          results_checked;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
               results_checked, what, got, want);
      error_count++;
   endtask

   function automatic longint shift_toward_zero(input longint v, input int sh);
      if (v < 0)
         return -((-v) >>> sh);
      return v >>> sh;
   endfunction

   function automatic void reset_model();
      model_cfg.counts_per_rev  = CPR_RESET;
      model_cfg.angle_per_count = APC_RESET;
      model_cfg.pole_pair_count = PP_RESET;
      model_cfg.speed_gain      = GAIN_RESET;
      model_cfg.speed_limit     = LIMIT_RESET;
      model_prev_latch          = '0;
      model_held_rpm            = '0;
   endfunction

   function automatic void apply_register_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                                input logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_COUNTS_PER_REV:  model_cfg.counts_per_rev  = data[COUNT_WIDTH-1:0];
         CSR_ANGLE_PER_COUNT: model_cfg.angle_per_count = data[APC_WIDTH-1:0];
         CSR_POLE_PAIR_COUNT: model_cfg.pole_pair_count = data[PP_WIDTH-1:0];
         CSR_SPEED_GAIN:      model_cfg.speed_gain      = data[GAIN_WIDTH-1:0];
         CSR_SPEED_LIMIT:     model_cfg.speed_limit     = data[LIMIT_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   // angle and speed prediction for one accepted sample, updates the speed state
   function automatic estimate_type predict_estimate(input sample_type s);
      longint       last;
      longint       now;
      longint       cpr;
      longint       diff;
      longint       rpm;
      longint       lim;
      longint       espd;
      logic [63:0]  mech;
      logic [63:0]  elec;
      estimate_type e;

      // count difference since the previous latch, wrapped by direction
      if (s.unit_timeout) begin
         last = longint'(model_prev_latch);
         now  = longint'(s.latched_position);
         cpr  = longint'(model_cfg.counts_per_rev);
         if (s.direction)
            diff = (last > now) ? (cpr - last + now) : (now - last);
         else
            diff = (last >= now) ? (now - last) : -(cpr - now + last);
         rpm = shift_toward_zero(diff * longint'(model_cfg.speed_gain), RPM_FRAC_BITS);
         lim = longint'(model_cfg.speed_limit);
         if (rpm > lim)
            rpm = lim;
         if (rpm < -lim)
            rpm = -lim;
         model_held_rpm   = SPEED_WIDTH'(rpm);
         model_prev_latch = s.latched_position;
      end

      // angles
      mech = (64'(s.position_count) * 64'(model_cfg.angle_per_count)) >> (32 - ANGLE_FRAC);
      if (mech > MECH_CEIL)
         mech = MECH_CEIL;
      elec = mech * 64'(model_cfg.pole_pair_count);
      if (elec > ELEC_CEIL)
         elec = ELEC_CEIL;

      // electrical speed from the held rpm
      espd = shift_toward_zero(longint'(model_held_rpm) * longint'(model_cfg.pole_pair_count)
                               * RAD_PER_RPM_Q20, ESPD_SHIFT);
      if (espd > ESPD_HIGH)
         espd = ESPD_HIGH;
      if (espd < ESPD_LOW)
         espd = ESPD_LOW;

      e.mech_angle = mech[MECH_WIDTH-1:0];
      e.elec_angle = elec[ELEC_WIDTH-1:0];
      e.speed_rpm  = model_held_rpm;
      e.elec_speed = ESPD_WIDTH'(espd);
      return e;
   endfunction

   function automatic sample_type make_sample(input int unsigned pos, input bit dir,
                                              input bit tmo, input int unsigned latch);
      sample_type s;
      s.position_count   = COUNT_WIDTH'(pos);
      s.direction        = dir;
      s.unit_timeout     = tmo;
      s.latched_position = COUNT_WIDTH'(latch);
      return s;
   endfunction

   function automatic cfg_type make_settings(input int unsigned cpr, input logic [31:0] apc,
                                             input int unsigned pp, input int unsigned gain,
                                             input int unsigned lim);
      cfg_type c;
      c.counts_per_rev  = COUNT_WIDTH'(cpr);
      c.angle_per_count = apc;
      c.pole_pair_count = PP_WIDTH'(pp);
      c.speed_gain      = GAIN_WIDTH'(gain);
      c.speed_limit     = LIMIT_WIDTH'(lim);
      return c;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      case ($urandom_range(0, 3))
         0:       c.counts_per_rev = 16'd1;
         1:       c.counts_per_rev = 16'hFFFF;
         default: c.counts_per_rev = COUNT_WIDTH'($urandom_range(2, 65534));
      endcase
      if ($urandom_range(0, 1))
         c.angle_per_count = 32'((64'd1 << 32) / c.counts_per_rev);
      else
         c.angle_per_count = $urandom();
      c.pole_pair_count = ($urandom_range(0, 4) == 0) ? PP_WIDTH'($urandom_range(0, 31))
                                                      : PP_WIDTH'($urandom_range(1, 16));
      c.speed_gain  = GAIN_WIDTH'($urandom_range(0, 65535));
      c.speed_limit = ($urandom_range(0, 3) == 0) ? 15'h7FFF
                                                  : LIMIT_WIDTH'($urandom_range(0, 32767));
      return c;
   endfunction

   // send one item, valid stays high on return so back-to-back items need no toggle
   task automatic send_sample(input sample_type s);
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.position_count   <= s.position_count;
      req_bus.direction        <= s.direction;
      req_bus.unit_timeout     <= s.unit_timeout;
      req_bus.latched_position <= s.latched_position;
      do @(posedge clock); while (!req_bus.ready);
      pending_estimates.push_back(predict_estimate(s));
      samples_sent++;
      if (s.unit_timeout)
         latches_sent++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_estimates.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_register_write(idx, data);
      writes_done++;
   endtask

   // program all registers, with junk above each field narrower than the data word, plus one write to a spare index
   task automatic load_registers(input cfg_type c);
      write_register(CSR_COUNTS_PER_REV,
                     {(CSR_DATA_WIDTH-COUNT_WIDTH)'($urandom()), c.counts_per_rev});
      write_register(CSR_ANGLE_PER_COUNT, c.angle_per_count);
      write_register(CSR_POLE_PAIR_COUNT,
                     {(CSR_DATA_WIDTH-PP_WIDTH)'($urandom()), c.pole_pair_count});
      write_register(CSR_SPEED_GAIN,
                     {(CSR_DATA_WIDTH-GAIN_WIDTH)'($urandom()), c.speed_gain});
      write_register(CSR_SPEED_LIMIT,
                     {(CSR_DATA_WIDTH-LIMIT_WIDTH)'($urandom()), c.speed_limit});
      write_register(CSR_INDEX_WIDTH'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                     $urandom());
      csr_bus.valid <= 1'b0;
      settings_loaded++;
   endtask

   // defaults straight out of reset
   task automatic test_reset_values();
      send_sample(make_sample(0, 1'b1, 1'b0, 0));
      send_sample(make_sample(65535, 1'b1, 1'b1, 1234));
      send_sample(make_sample(100, 1'b0, 1'b1, 1000));
      send_sample(make_sample(5000, 1'b1, 1'b0, 9));
   endtask

   // wrap in both directions, latches above the modulus, clamp at full scale
   task automatic test_wrap_and_limits();
      wait_for_results();
      load_registers(make_settings(10000, 32'hFFFF_FFFF, 16, 65535, 32767));
      send_sample(make_sample(65535, 1'b1, 1'b1, 9999));
      send_sample(make_sample(0, 1'b1, 1'b1, 5));
      send_sample(make_sample(1, 1'b0, 1'b1, 9990));
      send_sample(make_sample(40000, 1'b1, 1'b1, 60000));
      send_sample(make_sample(32768, 1'b1, 1'b1, 100));
      send_sample(make_sample(255, 1'b0, 1'b1, 65535));
      send_sample(make_sample(12345, 1'b0, 1'b0, 777));
   endtask

   // zero and maximum pole pairs, zero gain and limit, truncation of small negatives
   task automatic test_register_extremes();
      wait_for_results();
      load_registers(make_settings(10000, 2698608, 0, 1536, 5000));
      send_sample(make_sample(4321, 1'b1, 1'b1, 200));
      send_sample(make_sample(65535, 1'b0, 1'b1, 150));
      wait_for_results();
      load_registers(make_settings(1, 0, 31, 0, 0));
      send_sample(make_sample(65535, 1'b1, 1'b1, 3));
      send_sample(make_sample(7, 1'b0, 1'b1, 0));
      wait_for_results();
      load_registers(make_settings(65535, 32'hFFFF_FFFF, 31, 65535, 32767));
      send_sample(make_sample(65535, 1'b1, 1'b1, 30000));
      send_sample(make_sample(1, 1'b0, 1'b1, 0));
      wait_for_results();
      load_registers(make_settings(65535, 1, 1, 1, 32767));
      send_sample(make_sample(2, 1'b0, 1'b1, 65535));
      send_sample(make_sample(3, 1'b0, 1'b1, 65235));
   endtask

   // encoder-like motion with periodic latches, mixed with random noise samples
   task automatic run_motion_phase(input int n_items, input bit pause_midway);
      sample_type  s;
      int unsigned cpr;
      int unsigned step;
      cpr     = model_cfg.counts_per_rev;
      enc_pos = enc_pos % cpr;
      for (int i = 0; i < n_items; i++) begin
         if (pause_midway && i == n_items / 2)
            wait_for_results();
         if ($urandom_range(0, 99) < 15) begin
            s.position_count   = COUNT_WIDTH'($urandom());
            s.direction        = 1'($urandom());
            s.unit_timeout     = 1'($urandom());
            s.latched_position = COUNT_WIDTH'($urandom());
         end else begin
            if ($urandom_range(0, 19) == 0)
               enc_dir = ~enc_dir;
            step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cpr) : $urandom_range(0, 300);
            step = step % cpr;
            if (enc_dir)
               enc_pos = (enc_pos + step) % cpr;
            else
               enc_pos = (enc_pos + cpr - step) % cpr;
            s.position_count   = COUNT_WIDTH'(enc_pos);
            s.direction        = enc_dir;
            s.unit_timeout     = ($urandom_range(0, 3) == 0);
            s.latched_position = COUNT_WIDTH'(enc_pos);
         end
         send_sample(s);
      end
   endtask

   // several random settings, the last phase at full rate on both sides
   task automatic test_random_motion();
      for (int p = 0; p < 6; p++) begin
         wait_for_results();
         idle_enabled = (p != 5);
         load_registers(random_settings());
         run_motion_phase(105, p == 2);
      end
   endtask

   // result sink with random stall bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
         stall_left    <= $urandom_range(0, 7);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      estimate_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_estimates.size() == 0) begin
            report_mismatch("result with no sample outstanding", 1, 0);
         end else begin
            want = pending_estimates.pop_front();
            results_checked++;
            if (rsp_bus.mech_angle !== want.mech_angle)
               report_mismatch("mech_angle", rsp_bus.mech_angle, want.mech_angle);
            if (rsp_bus.elec_angle !== want.elec_angle)
               report_mismatch("elec_angle", rsp_bus.elec_angle, want.elec_angle);
            if (rsp_bus.speed_rpm !== want.speed_rpm)
               report_mismatch("speed_rpm", rsp_bus.speed_rpm, want.speed_rpm);
            if (rsp_bus.elec_speed !== want.elec_speed)
               report_mismatch("elec_speed", rsp_bus.elec_speed, want.elec_speed);
         end
      end
   end

   // test sequence
   initial begin
      req_bus.valid            = 1'b0;
      req_bus.position_count   = '0;
      req_bus.direction        = 1'b0;
      req_bus.unit_timeout     = 1'b0;
      req_bus.latched_position = '0;
      csr_bus.valid            = 1'b0;
      csr_bus.index            = '0;
      csr_bus.data             = '0;
      rsp_bus.ready            = 1'b0;
      idle_enabled             = 1'b1;
      stall_left               = 0;
      enc_pos                  = 0;
      enc_dir                  = 1'b1;
      reset_model();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_wrap_and_limits();
      test_register_extremes();
      test_random_motion();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_estimates.size() != 0)
         report_mismatch("estimates never produced", 0, pending_estimates.size());

      $display("covered %0d samples, %0d with a fresh latch, %0d results checked",
               samples_sent, latches_sent, results_checked);
      $display("register writes %0d across %0d settings, mismatches %0d",
               writes_done, settings_loaded, error_count);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("watchdog expired with %0d results outstanding", pending_estimates.size());
      $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/eas_pkg.sv
rtl/eas_if.sv
rtl/eas_csr.sv
rtl/eas_ctrl.sv
rtl/eas_dp.sv
rtl/encoder_angle_speed_estimator_unit.sv
rtl/eas_checker.sv
tb/encoder_angle_speed_estimator_unit_tb.sv
